>>> sv/jdc_pkg.sv
// Shared types, constants and lookup functions for the Julian day number converter.
package jdc_pkg;

  typedef enum logic {
    KIND_TO_SERIAL = 1'b0,
    KIND_TO_DATE   = 1'b1
  } kind_e;

  typedef struct packed {
    logic        kind;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [13:0] year_in;
    logic [22:0] serial_in;
  } in_item_t;

  typedef struct packed {
    logic [22:0] serial_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [13:0] year_out;
  } out_item_t;

  // Register stages in front of the output register.
  localparam int unsigned PipeStages = 6;

  // Date to day number constants.
  localparam logic [13:0] YearSmall   = 14'd100;
  localparam logic [13:0] YearCentury = 14'd1900;
  localparam logic [14:0] YearOffA    = 15'd4800;
  localparam logic [14:0] YearOffB    = 15'd4900;
  localparam logic [10:0] Mul1461     = 11'd1461;
  localparam logic [22:0] SerialBias  = 23'd32075;
  localparam logic [3:0]  MonthFeb    = 4'd2;

  // Day number to date constants.
  localparam logic [23:0] JdBias     = 24'd68569;
  localparam logic [17:0] Cyc400     = 18'd146097;
  localparam logic [15:0] DayBias    = 16'd31;
  localparam logic [13:0] YearBias   = 14'd4900;
  localparam logic [13:0] Mul100     = 14'd100;
  localparam logic [3:0]  MonthLimit = 4'd10;
  localparam logic [3:0]  MonthWrap  = 4'd10;
  localparam logic [3:0]  MonthShift = 4'd2;

  // Reciprocals for the constant divisions: floor(x*a/D) = (x*R) >> S with
  // R = ceil(a*2^S/D), where S is chosen so that x_max*(R*D - a*2^S) < 2^S.
  localparam int unsigned Sh100 = 19;
  localparam int unsigned ShN   = 42;
  localparam int unsigned ShI   = 37;
  localparam int unsigned ShJ   = 21;

  localparam longint unsigned Recip100Raw =
    ((64'd1 << Sh100) + 64'd99) / 64'd100;
  localparam longint unsigned RecipNRaw =
    ((64'd4 << ShN) + 64'd146096) / 64'd146097;
  localparam longint unsigned RecipIRaw =
    ((64'd4000 << ShI) + 64'd1461000) / 64'd1461001;
  localparam longint unsigned RecipJRaw =
    ((64'd80 << ShJ) + 64'd2446) / 64'd2447;

  localparam logic [12:0] Recip100 = 13'(Recip100Raw);
  localparam logic [26:0] RecipN   = 27'(RecipNRaw);
  localparam logic [28:0] RecipI   = 29'(RecipIRaw);
  localparam logic [16:0] RecipJ   = 17'(RecipJRaw);

  // floor(367 * x / 12) where x is the month shifted so that March is 1.
  function automatic logic [8:0] month_offset(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd305;
      4'd1:    r = 9'd336;
      4'd2:    r = 9'd367;
      4'd3:    r = 9'd30;
      4'd4:    r = 9'd61;
      4'd5:    r = 9'd91;
      4'd6:    r = 9'd122;
      4'd7:    r = 9'd152;
      4'd8:    r = 9'd183;
      4'd9:    r = 9'd214;
      4'd10:   r = 9'd244;
      4'd11:   r = 9'd275;
      4'd12:   r = 9'd305;
      4'd13:   r = 9'd336;
      4'd14:   r = 9'd367;
      default: r = 9'd397;
    endcase
    return r;
  endfunction

  // floor(2447 * j / 80): days before month index j of the March-based year.
  function automatic logic [8:0] jday_offset(input logic [3:0] j);
    logic [8:0] r;
    case (j)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd152;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd305;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd428;
      default: r = 9'd458;
    endcase
    return r;
  endfunction

endpackage

>>> sv/jdc_in_if.sv
// Request channel of the Julian day number converter.
interface jdc_in_if;
  logic              valid;
  logic              ready;
  jdc_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> sv/jdc_out_if.sv
// Response channel of the Julian day number converter.
interface jdc_out_if;
  logic               valid;
  logic               ready;
  jdc_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> sv/jdc_date2jd.sv
// Date to Julian day number datapath, six register stages.
module jdc_date2jd (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_i,
  input  logic [13:0] year_i,
  output logic [22:0] serial_o
);

  localparam int unsigned DelayDepth = jdc_pkg::PipeStages - 2;

  // Stage 1: year adjust and month terms.
  logic [13:0] year_adj;
  logic        early;
  logic [14:0] v1_d, v1_q;
  logic [14:0] v2_d, v2_q;
  logic [8:0]  t2_d, t2_q;
  logic [4:0]  day1_q;

  // Stage 2: products.
  logic [24:0] p1_full;
  logic [22:0] p1_d, p1_q;
  logic [26:0] p2_d, p2_q;
  logic [8:0]  t2b_q;
  logic [4:0]  day2_q;

  // Stage 3 and the delay line.
  logic [7:0]  cent;
  logic [9:0]  cent3;
  logic [22:0] serial_d;
  logic [22:0] ser_q [DelayDepth];

  always_comb begin
    year_adj = (year_i < jdc_pkg::YearSmall) ? year_i + jdc_pkg::YearCentury : year_i;
    // January and February count as months of the previous year.
    early    = (month_i <= jdc_pkg::MonthFeb);
    v1_d     = 15'(year_adj) + jdc_pkg::YearOffA - 15'(early);
    v2_d     = 15'(year_adj) + jdc_pkg::YearOffB - 15'(early);
    t2_d     = jdc_pkg::month_offset(month_i);
  end

  always_comb begin
    p1_full = 25'(v1_q) * 25'(jdc_pkg::Mul1461);
    p1_d    = p1_full[24:2];
    p2_d    = 27'(27'(v2_q) * 27'(jdc_pkg::Recip100));
  end

  always_comb begin
    cent     = p2_q[jdc_pkg::Sh100 +: 8];
    cent3    = 10'(cent) + {1'b0, cent, 1'b0};
    serial_d = p1_q + 23'(t2b_q) + 23'(day2_q) - 23'(cent3[9:2]) - jdc_pkg::SerialBias;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v1_q   <= v1_d;
      v2_q   <= v2_d;
      t2_q   <= t2_d;
      day1_q <= day_i;
      p1_q   <= p1_d;
      p2_q   <= p2_d;
      t2b_q  <= t2_q;
      day2_q <= day1_q;
      ser_q[0] <= serial_d;
      for (int unsigned k = 1; k < DelayDepth; k++) begin
        ser_q[k] <= ser_q[k-1];
      end
    end
  end

  assign serial_o = ser_q[DelayDepth-1];

endmodule

>>> sv/jdc_jd2date.sv
// Julian day number to date datapath, six register stages.
module jdc_jd2date (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [22:0] serial_i,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic [13:0] year_o
);

  logic [23:0] l1_q;
  logic [49:0] pn_d, pn_q;
  logic [23:0] l2c_q;
  logic [7:0]  n_d, n3_q, n4_q;
  logic [25:0] dn;
  logic [15:0] lrem_d, lrem_q, lrem4_q;
  logic [43:0] pi_d, pi_q;
  logic [6:0]  i_d, i5_q, i6_q;
  logic [17:0] yi;
  logic [15:0] l3_full;
  logic [8:0]  l3_d, l3_q, l3b_q;
  logic [13:0] yb_d, yb5_q, yb6_q;
  logic [24:0] pj_d, pj_q;
  logic [3:0]  j;
  logic        k;
  logic [8:0]  dfull;

  // Stage 2: quotient of the 400-year cycle by reciprocal multiply.
  assign pn_d = 50'(51'(l1_q) * 51'(jdc_pkg::RecipN));

  // Stage 3: cycle index and remainder within the cycle.
  always_comb begin
    n_d    = pn_q[jdc_pkg::ShN +: 8];
    dn     = 26'(n_d) * 26'(jdc_pkg::Cyc400) + 26'd3;
    lrem_d = 16'(l2c_q - 24'(dn[25:2]));
  end

  // Stage 4: year within the cycle by reciprocal multiply.
  assign pi_d = 44'(45'(17'(lrem_q) + 17'd1) * 45'(jdc_pkg::RecipI));

  // Stage 5: day within the March-based year and the century base.
  always_comb begin
    i_d     = pi_q[jdc_pkg::ShI +: 7];
    yi      = 18'(i_d) * 18'(jdc_pkg::Mul1461);
    l3_full = lrem4_q - yi[17:2] + jdc_pkg::DayBias;
    l3_d    = l3_full[8:0];
    yb_d    = 14'(n4_q) * jdc_pkg::Mul100 - jdc_pkg::YearBias;
  end

  // Stage 6: month index within the March-based year.
  assign pj_d = 25'(26'(l3_q) * 26'(jdc_pkg::RecipJ));

  // Output: months past December move into the next year.
  always_comb begin
    j       = pj_q[jdc_pkg::ShJ +: 4];
    k       = (j > jdc_pkg::MonthLimit);
    month_o = k ? j - jdc_pkg::MonthWrap : j + jdc_pkg::MonthShift;
    dfull   = l3b_q - jdc_pkg::jday_offset(j);
    day_o   = dfull[4:0];
    year_o  = yb6_q + 14'(i6_q) + 14'(k);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l1_q    <= 24'(serial_i) + jdc_pkg::JdBias;
      pn_q    <= pn_d;
      l2c_q   <= l1_q;
      n3_q    <= n_d;
      lrem_q  <= lrem_d;
      pi_q    <= pi_d;
      n4_q    <= n3_q;
      lrem4_q <= lrem_q;
      l3_q    <= l3_d;
      i5_q    <= i_d;
      yb5_q   <= yb_d;
      pj_q    <= pj_d;
      l3b_q   <= l3_q;
      i6_q    <= i5_q;
      yb6_q   <= yb5_q;
    end
  end

endmodule

>>> sv/julian_day_date_converter.sv
// Top level of the Julian day number converter.
//
// Converts a Gregorian date to its Julian day number (kind 0) or a Julian
// day number to a Gregorian date (kind 1) with the Fliegel-Van Flandern
// integer formulas. Each request on req_i yields exactly one response on
// rsp_o, in order. Fields that do not belong to the chosen kind are zero.
// Years below 100 are taken as 19xx. Inputs are not checked for validity.
//
// A response is valid once the request has passed the six datapath stages and the
// output register. Throughput is one request per cycle while rsp_o does not
// stall; both datapaths run side by side, with every stage registered under one
// shared enable.
//
// When rsp_o stalls with a response waiting, the whole pipeline holds and
// req_i.ready drops; nothing is lost or repeated. Reset clears all valid
// bits, so the block comes out of reset empty and ready.
module julian_day_date_converter (
  input  logic      clk_i,
  input  logic      rst_ni,
  jdc_in_if.sink    req_i,
  jdc_out_if.source rsp_o
);

  localparam int unsigned Stages = jdc_pkg::PipeStages;

  logic               en;
  logic               vld_q [Stages];
  logic               kind_q [Stages];
  logic               rsp_valid_q;
  jdc_pkg::out_item_t rsp_d, rsp_q;
  logic [22:0]        serial;
  logic [3:0]         month;
  logic [4:0]         day;
  logic [13:0]        year;

  assign en          = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = en;

  jdc_date2jd u_date2jd (
    .clk_i    (clk_i),
    .en_i     (en),
    .month_i  (req_i.payload.month_in),
    .day_i    (req_i.payload.day_in),
    .year_i   (req_i.payload.year_in),
    .serial_o (serial)
  );

  jdc_jd2date u_jd2date (
    .clk_i    (clk_i),
    .en_i     (en),
    .serial_i (req_i.payload.serial_in),
    .month_o  (month),
    .day_o    (day),
    .year_o   (year)
  );

  always_comb begin
    rsp_d = '0;
    if (kind_q[Stages-1] == jdc_pkg::KIND_TO_DATE) begin
      rsp_d.month_out = month;
      rsp_d.day_out   = day;
      rsp_d.year_out  = year;
    end else begin
      rsp_d.serial_out = serial;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned k = 0; k < Stages; k++) begin
        vld_q[k] <= 1'b0;
      end
      rsp_valid_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= req_i.valid;
      for (int unsigned k = 1; k < Stages; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
      rsp_valid_q <= vld_q[Stages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind_q[0] <= req_i.payload.kind;
      for (int unsigned k = 1; k < Stages; k++) begin
        kind_q[k] <= kind_q[k-1];
      end
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

endmodule

>>> verif/julian_day_date_converter_test.sv
// Self-checking testbench for the Julian day number converter, with random flow control.
module julian_day_date_converter_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_RANDOM,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_e;

  localparam int unsigned RandomItems = 880;
  localparam int unsigned DrainCycles = 4 * (jdc_pkg::PipeStages + 1);

  logic clk_i;
  logic rst_ni;

  jdc_in_if  req_if ();
  jdc_out_if rsp_if ();

  julian_day_date_converter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  jdc_pkg::out_item_t conversions_due[$];
  int unsigned        mismatches = 0;
  int unsigned        burst_left = 0;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Fliegel-Van Flandern conversion in 64-bit signed arithmetic; division
  // truncates toward zero and results wrap to the field widths.
  function automatic jdc_pkg::out_item_t convert_calendar(input jdc_pkg::in_item_t req);
    jdc_pkg::out_item_t res;
    longint             m, d, y, a, jd, l, n, i, j, k;
    res = '0;
    if (req.kind == jdc_pkg::KIND_TO_SERIAL) begin
      m = req.month_in;
      d = req.day_in;
      y = req.year_in;
      if (y < 100) begin
        y = y + 1900;
      end
      a  = (m - 14) / 12;
      jd = d - 32075 + 1461 * (y + 4800 + a) / 4 + 367 * (m - 2 - a * 12) / 12
         - 3 * ((y + 4900 + a) / 100) / 4;
      res.serial_out = jd[22:0];
    end else begin
      jd = req.serial_in;
      l  = jd + 68569;
      n  = 4 * l / 146097;
      l  = l - (146097 * n + 3) / 4;
      i  = 4000 * (l + 1) / 1461001;
      l  = l - 1461 * i / 4 + 31;
      j  = 80 * l / 2447;
      d  = l - 2447 * j / 80;
      k  = j / 11;
      m  = j + 2 - 12 * k;
      y  = 100 * (n - 49) + i + k;
      res.month_out = m[3:0];
      res.day_out   = d[4:0];
      res.year_out  = y[13:0];
    end
    return res;
  endfunction

  // A request with every field random.
  function automatic jdc_pkg::in_item_t random_request();
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    return noise[$bits(jdc_pkg::in_item_t)-1:0];
  endfunction

  // Fields that the chosen kind ignores carry random content.
  function automatic jdc_pkg::in_item_t date_request(input int unsigned m,
                                                     input int unsigned d,
                                                     input int unsigned y);
    jdc_pkg::in_item_t req;
    req          = random_request();
    req.kind     = jdc_pkg::KIND_TO_SERIAL;
    req.month_in = m[3:0];
    req.day_in   = d[4:0];
    req.year_in  = y[13:0];
    return req;
  endfunction

  function automatic jdc_pkg::in_item_t serial_request(input int unsigned s);
    jdc_pkg::in_item_t req;
    req           = random_request();
    req.kind      = jdc_pkg::KIND_TO_DATE;
    req.serial_in = s[22:0];
    return req;
  endfunction

  // Sends one request; the sender works in bursts separated by random gaps.
  task automatic send_request(input jdc_pkg::in_item_t req);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= req;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    conversions_due.push_back(convert_calendar(req));
    burst_left--;
  endtask

  task automatic test_date_extremes();
    send_request(date_request(1, 1, 0));
    send_request(date_request(12, 31, 99));
    send_request(date_request(1, 1, 100));
    send_request(date_request(12, 31, 9999));
    send_request(date_request(1, 1, 1));
    send_request(date_request(2, 29, 2000));
    send_request(date_request(3, 1, 1600));
    send_request(date_request(10, 15, 1582));
    // Invalid dates run through the formula unchanged.
    send_request(date_request(0, 15, 2020));
    send_request(date_request(13, 1, 2020));
    send_request(date_request(2, 0, 2023));
    send_request(date_request(2, 31, 2023));
    send_request(date_request(15, 31, 16383));
    send_request(date_request(0, 0, 0));
  endtask

  task automatic test_serial_extremes();
    send_request(serial_request(1721426));
    send_request(serial_request(5373484));
    send_request(serial_request(2299161));
    send_request(serial_request(2451545));
    send_request(serial_request(2440588));
    // Day numbers outside years 1 to 9999; the year wraps to its field width.
    send_request(serial_request(0));
    send_request(serial_request(1));
    send_request(serial_request(23'h7fffff));
  endtask

  task automatic test_random_conversions();
    jdc_pkg::in_item_t req;
    repeat (RandomItems) begin
      if ($urandom_range(0, 6) == 0) begin
        req = random_request();
      end else if ($urandom_range(0, 1) == 0) begin
        req = date_request($urandom_range(1, 12), $urandom_range(1, 31),
                           $urandom_range(0, 9999));
      end else begin
        req = serial_request($urandom_range(1721426, 5373484));
      end
      send_request(req);
    end
  endtask

  // Receiver readiness follows modes of random length.
  initial begin : rsp_stall_pattern
    stall_mode_e mode;
    int unsigned span;
    rsp_if.ready = 1'b0;
    forever begin
      mode = stall_mode_e'($urandom_range(0, 3));
      span = $urandom_range(4, 60);
      repeat (span) begin
        @(posedge clk_i);
        case (mode)
          STALL_NONE:   rsp_if.ready <= 1'b1;
          STALL_RANDOM: rsp_if.ready <= ($urandom_range(0, 1) == 0);
          STALL_HEAVY:  rsp_if.ready <= ($urandom_range(0, 3) == 0);
          default:      rsp_if.ready <= ~rsp_if.ready;
        endcase
      end
    end
  end

  task automatic check_field(input string name, input logic [22:0] expected,
                             input logic [22:0] actual);
    if (actual !== expected) begin
      $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    jdc_pkg::out_item_t due;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (conversions_due.size() == 0) begin
        $error("response with no request outstanding");
        mismatches++;
      end else begin
        due = conversions_due.pop_front();
        check_field("serial_out", due.serial_out, rsp_if.payload.serial_out);
        check_field("month_out", 23'(due.month_out), 23'(rsp_if.payload.month_out));
        check_field("day_out", 23'(due.day_out), 23'(rsp_if.payload.day_out));
        check_field("year_out", 23'(due.year_out), 23'(rsp_if.payload.year_out));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rst_ni         = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_date_extremes();
    test_serial_extremes();
    test_random_conversions();
    req_if.valid <= 1'b0;
    while (conversions_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
